// ===== rtl/core/tcsa_pkg.sv =====
`default_nettype none
package tcsa_pkg;

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_ACCUM = 2'd1,
    OP_READ  = 2'd2,
    OP_CLEAR = 2'd3
  } opcode_t;

  typedef enum logic [2:0] {
    REG_IN_CH   = 3'd0,
    REG_OUT_CH  = 3'd1,
    REG_KH      = 3'd2,
    REG_KW      = 3'd3,
    REG_STRIDE_R = 3'd4,
    REG_STRIDE_C = 3'd5,
    REG_ROWS    = 3'd6,
    REG_COLS    = 3'd7
  } reg_index_t;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 7;
  localparam int unsigned VALUE_W    = 16;
  localparam int unsigned ACC_W      = 32;

  // controller to datapath
  typedef struct packed {
    logic capture;    // latch the accepted item
    logic wload;      // write weight store
    logic oclear;     // write zero at sweep address
    logic macread;    // issue reads for current tap
    logic macwrite;   // write back tap result
    logic rdissue;    // issue read for output read
    logic rdcapture;  // capture read data into result register
    logic step;       // advance tap counters
    logic sweep_step; // advance clear address
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [1:0] op;
    logic       ch_ok;     // accumulate channel in use
    logic       tap_last;  // current tap is the final one
    logic       sweep_last;
  } dp_stat_t;

endpackage
`default_nettype wire

// ===== rtl/core/tcsa_ram.sv =====
`default_nettype none
module tcsa_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== rtl/core/tcsa_datapath.sv =====
`default_nettype none
module tcsa_datapath #(
  parameter int unsigned MAX_IN_CH   = 16,
  parameter int unsigned MAX_OUT_CH  = 16,
  parameter int unsigned MAX_KERNEL  = 4,
  parameter int unsigned MAX_OUT_DIM = 64
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                cfg_we,
  input  wire logic [2:0]          cfg_idx,
  input  wire logic [6:0]          cfg_data,
  input  wire logic [63:0]         item,
  input  wire tcsa_pkg::dp_cmd_t   cmd,
  output      tcsa_pkg::dp_stat_t  stat,
  output      logic [31:0]         res_value,
  output      logic                res_oor
);
  localparam int unsigned OCW = (MAX_OUT_CH > 1) ? $clog2(MAX_OUT_CH) : 1;
  localparam int unsigned ICW = (MAX_IN_CH > 1) ? $clog2(MAX_IN_CH) : 1;
  localparam int unsigned KW  = (MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1;
  localparam int unsigned DW  = $clog2(MAX_OUT_DIM);
  localparam int unsigned WAW = OCW + ICW + 2 * KW;
  localparam int unsigned OAW = OCW + 2 * DW;
  localparam int unsigned WDEPTH = 1 << WAW;
  localparam int unsigned ODEPTH = 1 << OAW;

  // configuration registers
  logic [4:0] in_ch_r, out_ch_r;
  logic [2:0] kh_r, kw_r, sr_r, sc_r;
  logic [6:0] rows_r, cols_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_ch_r <= 5'd1; out_ch_r <= 5'd1; kh_r <= 3'd3; kw_r <= 3'd3;
      sr_r <= 3'd1; sc_r <= 3'd1; rows_r <= 7'd64; cols_r <= 7'd64;
    end else if (cfg_we) begin
      unique case (tcsa_pkg::reg_index_t'(cfg_idx))
        tcsa_pkg::REG_IN_CH:    in_ch_r  <= cfg_data[4:0];
        tcsa_pkg::REG_OUT_CH:   out_ch_r <= cfg_data[4:0];
        tcsa_pkg::REG_KH:       kh_r     <= cfg_data[2:0];
        tcsa_pkg::REG_KW:       kw_r     <= cfg_data[2:0];
        tcsa_pkg::REG_STRIDE_R: sr_r     <= cfg_data[2:0];
        tcsa_pkg::REG_STRIDE_C: sc_r     <= cfg_data[2:0];
        tcsa_pkg::REG_ROWS:     rows_r   <= cfg_data;
        tcsa_pkg::REG_COLS:     cols_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  // clamped limits, as 9-bit values
  logic [8:0] n_ic, n_oc, n_kh, n_kw, n_rows, n_cols;
  always_comb begin
    n_ic   = (32'(in_ch_r)  > MAX_IN_CH)   ? 9'(MAX_IN_CH)   : 9'(in_ch_r);
    n_oc   = (32'(out_ch_r) > MAX_OUT_CH)  ? 9'(MAX_OUT_CH)  : 9'(out_ch_r);
    n_kh   = (32'(kh_r)     > MAX_KERNEL)  ? 9'(MAX_KERNEL)  : 9'(kh_r);
    n_kw   = (32'(kw_r)     > MAX_KERNEL)  ? 9'(MAX_KERNEL)  : 9'(kw_r);
    n_rows = (32'(rows_r)   > MAX_OUT_DIM) ? 9'(MAX_OUT_DIM) : 9'(rows_r);
    n_cols = (32'(cols_r)   > MAX_OUT_DIM) ? 9'(MAX_OUT_DIM) : 9'(cols_r);
  end

  // item register
  logic [1:0]  op_r;
  logic [3:0]  ch1_r, ch2_r;
  logic [5:0]  row_r, col_r;
  logic signed [15:0] val_r;
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r  <= item[1:0];
      ch1_r <= item[5:2];
      ch2_r <= item[9:6];
      row_r <= item[15:10];
      col_r <= item[21:16];
      val_r <= item[37:22];
    end
  end

  // tap counters: oc, ky, kx
  logic [8:0] oc_r, ky_r, kx_r;
  logic       kx_last, ky_last, oc_last;
  assign kx_last = (kx_r + 9'd1 >= n_kw);
  assign ky_last = (ky_r + 9'd1 >= n_kh);
  assign oc_last = (oc_r + 9'd1 >= n_oc);
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      oc_r <= '0; ky_r <= '0; kx_r <= '0;
    end else if (cmd.step) begin
      if (!kx_last) kx_r <= kx_r + 9'd1;
      else begin
        kx_r <= '0;
        if (!ky_last) ky_r <= ky_r + 9'd1;
        else begin
          ky_r <= '0;
          oc_r <= oc_r + 9'd1;
        end
      end
    end
  end

  // scatter target of the current tap
  logic [10:0] orow, ocol;
  logic        tap_ok;
  assign orow = 11'(row_r) * 11'(sr_r) + 11'(ky_r);
  assign ocol = 11'(col_r) * 11'(sc_r) + 11'(kx_r);
  assign tap_ok = (n_oc != 0) && (n_kh != 0) && (n_kw != 0)
                  && (orow < 11'(n_rows)) && (ocol < 11'(n_cols));

  // clear sweep address, also starts from zero for the sweep after reset
  logic [OAW:0] sweep_r;
  always_ff @(posedge clk) begin
    if (!rst_n) sweep_r <= '0;
    else if (cmd.capture) sweep_r <= '0;
    else if (cmd.sweep_step) sweep_r <= sweep_r + 1'b1;
  end

  // weight store
  logic [WAW-1:0] w_waddr, w_raddr;
  logic [15:0]    w_rdata;
  logic           w_in_range;
  assign w_in_range = (32'(ch1_r) < MAX_OUT_CH) && (32'(ch2_r) < MAX_IN_CH)
                      && (32'(row_r) < MAX_KERNEL) && (32'(col_r) < MAX_KERNEL);
  assign w_waddr = {OCW'(ch1_r), ICW'(ch2_r), KW'(row_r), KW'(col_r)};
  assign w_raddr = {OCW'(oc_r), ICW'(ch1_r), KW'(ky_r), KW'(kx_r)};

  tcsa_ram #(.WIDTH(16), .DEPTH(WDEPTH)) u_wram (
    .clk(clk), .we(cmd.wload && w_in_range), .waddr(w_waddr), .wdata(val_r),
    .raddr(w_raddr), .rdata(w_rdata)
  );

  // output store
  logic [OAW-1:0] o_tap_addr, o_rd_addr, o_waddr, tap_addr_r;
  logic [31:0]    o_rdata, o_wdata;
  logic           o_we, tap_ok_r;
  assign o_tap_addr = {OCW'(oc_r), DW'(orow), DW'(ocol)};
  assign o_rd_addr  = cmd.rdissue ? {OCW'(ch1_r), DW'(row_r), DW'(col_r)} : o_tap_addr;

  always_ff @(posedge clk) begin
    if (cmd.macread) begin
      tap_addr_r <= o_tap_addr;
      tap_ok_r   <= tap_ok;
    end
  end

  // multiply then saturating add, or zero during a clear
  logic signed [31:0] prod;
  logic signed [32:0] sum;
  assign prod = val_r * $signed(w_rdata);
  assign sum  = 33'(signed'(o_rdata)) + 33'(prod);
  always_comb begin
    if (sum > 33'sh0_7FFF_FFFF)       o_wdata = 32'h7FFF_FFFF;
    else if (sum < -33'sh0_8000_0000) o_wdata = 32'h8000_0000;
    else                              o_wdata = sum[31:0];
    if (cmd.oclear) o_wdata = '0;
  end
  assign o_we    = cmd.oclear || (cmd.macwrite && tap_ok_r);
  assign o_waddr = cmd.oclear ? sweep_r[OAW-1:0] : tap_addr_r;

  tcsa_ram #(.WIDTH(32), .DEPTH(ODEPTH)) u_oram (
    .clk(clk), .we(o_we), .waddr(o_waddr), .wdata(o_wdata),
    .raddr(o_rd_addr), .rdata(o_rdata)
  );

  // read result
  logic rd_bad_r;
  always_ff @(posedge clk) begin
    if (cmd.rdissue)
      rd_bad_r <= (9'(ch1_r) >= n_oc) || (9'(row_r) >= n_rows) || (9'(col_r) >= n_cols);
    if (cmd.rdcapture) begin
      res_value <= rd_bad_r ? 32'd0 : o_rdata;
      res_oor   <= rd_bad_r;
    end
  end

  assign stat.op         = op_r;
  assign stat.ch_ok      = (9'(ch1_r) < n_ic) && (n_oc != 0) && (n_kh != 0) && (n_kw != 0);
  assign stat.tap_last   = kx_last && ky_last && oc_last;
  assign stat.sweep_last = (sweep_r == (OAW+1)'(ODEPTH - 1));
endmodule
`default_nettype wire

// ===== rtl/core/tcsa_ctrl.sv =====
`default_nettype none
module tcsa_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_fire,
  output      logic               in_ready,
  output      logic               res_valid,
  input  wire logic               res_take,
  input  wire tcsa_pkg::dp_stat_t stat,
  output      tcsa_pkg::dp_cmd_t  cmd
);
  typedef enum logic [2:0] {
    S_IDLE, S_DECODE, S_MREAD, S_MWAIT, S_MWRITE, S_CLEAR, S_RWAIT, S_RCAP
  } state_t;

  state_t state_r, state_nxt;
  logic   res_valid_r, res_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    res_valid_nxt = res_valid_r;
    cmd           = '0;
    if (res_take) res_valid_nxt = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        cmd.capture = in_fire;
        if (in_fire) state_nxt = S_DECODE;
      end
      S_DECODE: begin
        unique case (tcsa_pkg::opcode_t'(stat.op))
          tcsa_pkg::OP_LOAD: begin
            cmd.wload = 1'b1;
            state_nxt = S_IDLE;
          end
          tcsa_pkg::OP_ACCUM: state_nxt = stat.ch_ok ? S_MREAD : S_IDLE;
          tcsa_pkg::OP_READ: begin
            cmd.rdissue = 1'b1;
            state_nxt   = S_RWAIT;
          end
          tcsa_pkg::OP_CLEAR: state_nxt = S_CLEAR;
          default: state_nxt = S_IDLE;
        endcase
      end
      S_MREAD: begin
        cmd.macread = 1'b1;
        state_nxt   = S_MWAIT;
      end
      S_MWAIT: state_nxt = S_MWRITE;
      S_MWRITE: begin
        cmd.macwrite = 1'b1;
        cmd.step     = 1'b1;
        state_nxt    = stat.tap_last ? S_IDLE : S_MREAD;
      end
      S_CLEAR: begin
        cmd.oclear     = 1'b1;
        cmd.sweep_step = 1'b1;
        if (stat.sweep_last) state_nxt = S_IDLE;
      end
      // hold the read address so the registered read data stays on it
      S_RWAIT: begin
        cmd.rdissue = 1'b1;
        state_nxt   = S_RCAP;
      end
      S_RCAP: begin
        cmd.rdissue = 1'b1;
        if (!res_valid_r || res_take) begin
          cmd.rdcapture = 1'b1;
          res_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      res_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      res_valid_r <= res_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign res_valid = res_valid_r;

`ifndef SYNTHESIS
  a_one_write_src: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.oclear && cmd.macwrite)) else $error("clear and mac write together");
  a_capture_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.capture |=> state_r == S_DECODE) else $error("capture without decode");
  a_rdcap_slot: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rdcapture |-> (!res_valid_r || res_take)) else $error("result overwritten");
`endif
endmodule
`default_nettype wire

// ===== rtl/core/transposed_conv2d_scatter_accumulate_top.sv =====
`default_nettype none
// transposed 2d convolution by scatter-accumulate, one image, q8.8 in and
// q16.16 saturating accumulators. items travel on in_* (opcode load weight,
// accumulate, read, clear); only a read gives a transfer on out_*. one item at
// a time: each is captured and decoded; then a load writes its weight, a read
// waits on the output memory and for a free result slot, an accumulate runs
// out_channel_count x kernel_height x kernel_width taps (each a read, multiply
// and read-modify-write through the single-port-write output memory), and a
// clear sweeps the whole output memory at one entry a cycle (65536 entries at
// defaults). after reset the same sweep runs before the first item is taken,
// so in_tready is low during it. unwritten weights read as undefined.
module transposed_conv2d_scatter_accumulate_top #(
  parameter int unsigned MAX_IN_CH   = 16,
  parameter int unsigned MAX_OUT_CH  = 16,
  parameter int unsigned MAX_KERNEL  = 4,
  parameter int unsigned MAX_OUT_DIM = 64
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [6:0]  cfg_data,
  input  wire logic        in_tvalid,
  output      logic        in_tready,
  // opcode[1:0], first_channel[5:2], second_channel[9:6], row[15:10],
  // col[21:16], value[37:22], zero fill to 40
  input  wire logic [39:0] in_tdata,
  output      logic        out_tvalid,
  input  wire logic        out_tready,
  // out_value[31:0], out_of_range[32], zero fill to 40
  output      logic [39:0] out_tdata
);
  tcsa_pkg::dp_cmd_t  cmd;
  tcsa_pkg::dp_stat_t stat;
  logic [31:0] res_value;
  logic        res_oor;

  tcsa_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n),
    .in_fire(in_tvalid && in_tready), .in_ready(in_tready),
    .res_valid(out_tvalid), .res_take(out_tvalid && out_tready),
    .stat(stat), .cmd(cmd)
  );

  tcsa_datapath #(
    .MAX_IN_CH(MAX_IN_CH), .MAX_OUT_CH(MAX_OUT_CH),
    .MAX_KERNEL(MAX_KERNEL), .MAX_OUT_DIM(MAX_OUT_DIM)
  ) u_dp (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_idx(cfg_index), .cfg_data(cfg_data),
    .item({24'd0, in_tdata}), .cmd(cmd), .stat(stat),
    .res_value(res_value), .res_oor(res_oor)
  );

  assign out_tdata = {7'd0, res_oor, res_value};
endmodule
`default_nettype wire

// ===== sim/tb_transposed_conv2d_scatter_accumulate_top.sv =====
`timescale 1ns / 100ps

module tb_transposed_conv2d_scatter_accumulate_top;

  // generous ceiling: several output-store sweeps, worst-case accumulates at
  // the largest settings, and random gaps and stalls on both sides
  localparam longint CYCLE_LIMIT = 8_000_000;

  // scoreboard: a shadow of the weight and output stores, updated in order of
  // accepted input transfers, plus the read results still to come
  class deconv_scoreboard;
    int unsigned in_ch, out_ch, k_rows, k_cols, str_r, str_c, rows, cols;
    logic signed [15:0] weights [4096];
    int acc [65536];
    logic [32:0] pending_reads [$];
    int errors;

    function new();
      in_ch = 1; out_ch = 1; k_rows = 3; k_cols = 3;
      str_r = 1; str_c = 1; rows = 64; cols = 64;
      errors = 0;
      foreach (weights[i]) weights[i] = '0;
      foreach (acc[i]) acc[i] = 0;
    endfunction

    function int unsigned lim(int unsigned v, int unsigned top);
      return (v > top) ? top : v;
    endfunction

    function void set_reg(tcsa_pkg::reg_index_t idx, int unsigned v);
      case (idx)
        tcsa_pkg::REG_IN_CH:    in_ch  = v & 5'h1f;
        tcsa_pkg::REG_OUT_CH:   out_ch = v & 5'h1f;
        tcsa_pkg::REG_KH:       k_rows = v & 3'h7;
        tcsa_pkg::REG_KW:       k_cols = v & 3'h7;
        tcsa_pkg::REG_STRIDE_R: str_r  = v & 3'h7;
        tcsa_pkg::REG_STRIDE_C: str_c  = v & 3'h7;
        tcsa_pkg::REG_ROWS:     rows   = v & 7'h7f;
        tcsa_pkg::REG_COLS:     cols   = v & 7'h7f;
        default: ;
      endcase
    endfunction

    function void note_input(logic [39:0] d);
      tcsa_pkg::opcode_t op;
      int unsigned ch1, ch2, r, c, orow, ocol, n_oc, kh, kw, orows, ocols;
      longint s, act;
      int idx;
      op = tcsa_pkg::opcode_t'(d[1:0]);
      ch1 = d[5:2];
      ch2 = d[9:6];
      r = d[15:10];
      c = d[21:16];
      act = longint'($signed(d[37:22]));
      n_oc = lim(out_ch, 16);
      kh = lim(k_rows, 4);
      kw = lim(k_cols, 4);
      orows = lim(rows, 64);
      ocols = lim(cols, 64);
      case (op)
        tcsa_pkg::OP_LOAD: begin
          if (r < 4 && c < 4) weights[((ch1 * 16 + ch2) * 4 + r) * 4 + c] = d[37:22];
        end
        tcsa_pkg::OP_ACCUM: begin
          if (ch1 < lim(in_ch, 16)) begin
            for (int oc = 0; oc < n_oc; oc++)
              for (int ky = 0; ky < kh; ky++)
                for (int kx = 0; kx < kw; kx++) begin
                  orow = r * str_r + ky;
                  ocol = c * str_c + kx;
                  if (orow < orows && ocol < ocols) begin
                    idx = oc * 4096 + orow * 64 + ocol;
                    s = longint'(acc[idx])
                        + act * longint'(weights[((oc * 16 + ch1) * 4 + ky) * 4 + kx]);
                    if (s > 64'sd2147483647) s = 64'sd2147483647;
                    if (s < -64'sd2147483648) s = -64'sd2147483648;
                    acc[idx] = int'(s);
                  end
                end
          end
        end
        tcsa_pkg::OP_READ: begin
          if (ch1 >= n_oc || r >= orows || c >= ocols) pending_reads.push_back({1'b1, 32'd0});
          else pending_reads.push_back({1'b0, acc[ch1 * 4096 + r * 64 + c]});
        end
        default: begin
          foreach (acc[i]) acc[i] = 0;
        end
      endcase
    endfunction

    function void check_result(logic [39:0] d);
      logic [32:0] exp_word;
      if (pending_reads.size() == 0) begin
        $display("%0t: unexpected result, value %h flag %b", $realtime, d[31:0], d[32]);
        errors++;
        return;
      end
      exp_word = pending_reads.pop_front();
      if (d[31:0] !== exp_word[31:0]) begin
        $display("%0t: out_value mismatch, expected %h actual %h", $realtime,
                 exp_word[31:0], d[31:0]);
        errors++;
      end
      if (d[32] !== exp_word[32]) begin
        $display("%0t: out_of_range mismatch, expected %b actual %b", $realtime,
                 exp_word[32], d[32]);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [6:0]  cfg_data = '0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;

  deconv_scoreboard sb = new();
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned hold_off = 0;
  longint cycle_count = 0;

  transposed_conv2d_scatter_accumulate_top i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always #1 clk = ~clk;

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // transfer monitors, sampled at the rising edge
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) sb.note_input(in_tdata);
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata);
  end

  // result side back-pressure; a requested hold-off keeps tready low for a
  // long stretch so the block fills and stops taking input
  always @(negedge clk) begin
    if (hold_off > 0) begin
      out_tready = 1'b0;
      hold_off = hold_off - 1;
    end else begin
      out_tready = ($urandom_range(99) >= stall_pct);
    end
  end

  function automatic logic [39:0] pack_item(tcsa_pkg::opcode_t op, int unsigned ch1,
                                            int unsigned ch2, int unsigned r,
                                            int unsigned c, int v);
    return {2'b00, 16'(v), 6'(c), 6'(r), 4'(ch2), 4'(ch1), op};
  endfunction

  function automatic int rand_value();
    case ($urandom_range(7))
      0: return -32768;
      1: return 32767;
      default: return int'($urandom_range(65535)) - 32768;
    endcase
  endfunction

  // pick an index mostly inside [0, top-1], sometimes anywhere in the field
  function automatic int unsigned mostly_below(int unsigned top, int unsigned field_max);
    if (top == 0 || $urandom_range(99) < 15) return $urandom_range(field_max);
    return $urandom_range(top - 1);
  endfunction

  // random traffic shaped by the current settings so most accumulates land
  // inside the output plane and most reads hit live entries
  function automatic logic [39:0] rand_item();
    int unsigned pick, rspan, cspan;
    pick = $urandom_range(99);
    if (pick < 25)
      return pack_item(tcsa_pkg::OP_LOAD, $urandom_range(15), $urandom_range(15),
                       ($urandom_range(9) == 0) ? $urandom_range(63) : $urandom_range(3),
                       ($urandom_range(9) == 0) ? $urandom_range(63) : $urandom_range(3),
                       rand_value());
    if (pick < 65) begin
      rspan = (sb.str_r == 0) ? 64 : sb.lim(sb.rows, 64) / sb.str_r + 1;
      cspan = (sb.str_c == 0) ? 64 : sb.lim(sb.cols, 64) / sb.str_c + 1;
      return pack_item(tcsa_pkg::OP_ACCUM, mostly_below(sb.lim(sb.in_ch, 16), 15),
                       $urandom_range(15),
                       mostly_below(sb.lim(rspan, 64), 63),
                       mostly_below(sb.lim(cspan, 64), 63), rand_value());
    end
    return pack_item(tcsa_pkg::OP_READ, mostly_below(sb.lim(sb.out_ch, 16), 15),
                     $urandom_range(15),
                     mostly_below(sb.lim(sb.rows, 64), 63),
                     mostly_below(sb.lim(sb.cols, 64), 63), rand_value());
  endfunction

  // entered and left just after a falling edge; tvalid stays up for the next item
  task automatic send(logic [39:0] item);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid = 1'b0;
      in_tdata = {2'b00, 38'($urandom())};
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata = item;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  // closing read: its result can only come once every earlier item is done
  task automatic settle();
    send(pack_item(tcsa_pkg::OP_READ, 0, 0, 0, 0, 0));
    in_tvalid = 1'b0;
    while (sb.pending_reads.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_reg(tcsa_pkg::reg_index_t idx, int unsigned v);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = 7'(v);
    sb.set_reg(idx, v);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic set_config(int unsigned ic, int unsigned oc, int unsigned kh,
                            int unsigned kw, int unsigned sr, int unsigned sc,
                            int unsigned nr, int unsigned nc);
    write_reg(tcsa_pkg::REG_IN_CH, ic);
    write_reg(tcsa_pkg::REG_OUT_CH, oc);
    write_reg(tcsa_pkg::REG_KH, kh);
    write_reg(tcsa_pkg::REG_KW, kw);
    write_reg(tcsa_pkg::REG_STRIDE_R, sr);
    write_reg(tcsa_pkg::REG_STRIDE_C, sc);
    write_reg(tcsa_pkg::REG_ROWS, nr);
    write_reg(tcsa_pkg::REG_COLS, nc);
  endtask

  // one random phase; idling mode rotates every 50 items
  task automatic run_random(int n, bit with_clear, bit with_pressure);
    if (with_clear) send(pack_item(tcsa_pkg::OP_CLEAR, 0, 0, 0, 0, 0));
    if (with_pressure) hold_off = 3000;
    for (int k = 0; k < n; k++) begin
      case ((k / 50) % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 70; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 70; end
        default: begin send_idle_pct = 38; stall_pct = 38; end
      endcase
      send(rand_item());
    end
    send_idle_pct = 0;
    stall_pct = 0;
    settle();
  endtask

  initial begin
    repeat (10) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // fill every weight so no accumulate ever touches an unwritten one
    for (int oc = 0; oc < 16; oc++)
      for (int ic = 0; ic < 16; ic++)
        for (int ky = 0; ky < 4; ky++)
          for (int kx = 0; kx < 4; kx++)
            send(pack_item(tcsa_pkg::OP_LOAD, oc, ic, ky, kx, rand_value()));

    // directed: reset settings, read of the swept store, then a clear
    send(pack_item(tcsa_pkg::OP_READ, 0, 0, 5, 7, 0));
    send(pack_item(tcsa_pkg::OP_CLEAR, 0, 0, 0, 0, 0));
    send(pack_item(tcsa_pkg::OP_LOAD, 15, 15, 3, 3, -32768));
    send(pack_item(tcsa_pkg::OP_LOAD, 0, 0, 0, 0, 32767));
    send(pack_item(tcsa_pkg::OP_LOAD, 3, 2, 4, 0, 1234));  // kernel row beyond store: ignored
    send(pack_item(tcsa_pkg::OP_LOAD, 0, 0, 0, 63, -1));   // kernel column beyond store: ignored
    send(pack_item(tcsa_pkg::OP_ACCUM, 0, 0, 0, 0, 32767));
    send(pack_item(tcsa_pkg::OP_READ, 0, 0, 0, 0, 0));
    send(pack_item(tcsa_pkg::OP_ACCUM, 0, 0, 0, 0, 32767));
    send(pack_item(tcsa_pkg::OP_ACCUM, 0, 0, 0, 0, 32767)); // positive saturation
    send(pack_item(tcsa_pkg::OP_READ, 0, 0, 0, 0, 0));
    send(pack_item(tcsa_pkg::OP_ACCUM, 0, 0, 0, 0, -32768));
    for (int k = 0; k < 5; k++) send(pack_item(tcsa_pkg::OP_ACCUM, 0, 0, 0, 0, -32768));
    send(pack_item(tcsa_pkg::OP_READ, 0, 0, 0, 0, 0));      // negative saturation
    send(pack_item(tcsa_pkg::OP_ACCUM, 0, 0, 63, 63, 256)); // partly off the plane
    send(pack_item(tcsa_pkg::OP_READ, 0, 0, 63, 63, 0));
    send(pack_item(tcsa_pkg::OP_ACCUM, 5, 0, 1, 1, 500));   // channel not in use
    send(pack_item(tcsa_pkg::OP_READ, 0, 15, 1, 1, 0));
    send(pack_item(tcsa_pkg::OP_READ, 15, 0, 0, 0, 0));     // channel out of range
    send(pack_item(tcsa_pkg::OP_CLEAR, 0, 0, 0, 0, 0));
    send(pack_item(tcsa_pkg::OP_READ, 0, 0, 1, 2, 0));
    settle();

    // random phases over a spread of settings, extremes included
    set_config(16, 16, 4, 4, 4, 4, 64, 64);
    run_random(50, 1'b0, 1'b0);
    set_config(2, 3, 2, 3, 2, 1, 8, 8);
    run_random(200, 1'b1, 1'b1);
    set_config(0, 0, 0, 0, 0, 0, 0, 0);
    run_random(50, 1'b0, 1'b0);
    set_config(31, 31, 7, 7, 7, 7, 127, 127);
    run_random(50, 1'b0, 1'b0);
    set_config(4, 2, 3, 2, 3, 2, 20, 33);
    run_random(200, 1'b1, 1'b0);
    set_config(1, 1, 1, 1, 1, 1, 1, 1);
    run_random(150, 1'b0, 1'b1);
    set_config($urandom_range(31), $urandom_range(31), $urandom_range(7), $urandom_range(7),
               $urandom_range(7), $urandom_range(7), $urandom_range(127), $urandom_range(127));
    run_random(150, 1'b1, 1'b0);
    set_config(3, 5, 4, 1, 0, 3, 12, 40);
    run_random(150, 1'b0, 1'b0);

    repeat (50) @(negedge clk);
    if (sb.errors == 0 && sb.pending_reads.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== transposed_conv2d_scatter_accumulate_top.f =====
rtl/core/tcsa_pkg.sv
rtl/core/tcsa_ram.sv
rtl/core/tcsa_datapath.sv
rtl/core/tcsa_ctrl.sv
rtl/core/transposed_conv2d_scatter_accumulate_top.sv
sim/tb_transposed_conv2d_scatter_accumulate_top.sv
